### src/cube_map_light_accumulate_macros.svh
// Assertion helpers for the cube map light accumulate block.
`ifndef CUBE_MAP_LIGHT_ACCUMULATE_MACROS_SVH
`define CUBE_MAP_LIGHT_ACCUMULATE_MACROS_SVH

// Same-cycle implication, off during reset.
`define CMLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define CMLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/cmla_pkg.sv
package cmla_pkg;

  localparam int FACE_SIZE_DEF = 16;
  localparam int FACE_W        = 3;
  localparam int TEXEL_W       = 4;
  localparam int COL_W         = 16;
  localparam int DIR_W         = 16;
  localparam int EXP_W         = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int EXP_MAX       = 32;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR_X   = 3'd0,
    CFG_DIR_Y   = 3'd1,
    CFG_DIR_Z   = 3'd2,
    CFG_RED     = 3'd3,
    CFG_GREEN   = 3'd4,
    CFG_BLUE    = 3'd5,
    CFG_EXPONENT = 3'd6
  } cfg_reg_t;

  typedef enum logic [FACE_W-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  localparam logic signed [DIR_W-1:0] DIR_X_RST = 16'sd32767;
  localparam logic signed [DIR_W-1:0] DIR_Y_RST = 16'sd0;
  localparam logic signed [DIR_W-1:0] DIR_Z_RST = 16'sd0;
  localparam logic [COL_W-1:0]        COL_RST   = 16'd4096;
  localparam logic [EXP_W-1:0]        EXP_RST   = 6'd1;

endpackage

### src/cube_map_light_accumulate.sv
// 85 register stages from the accepted input word to the result word.
// Throughput: one word per cycle while the output is not stalled; the 31-stage restoring divider, 16-stage square root
// and 31-stage power chain are fully pipelined, one compare-subtract or multiply each.
// A one-word skid register keeps in_ready up for one word while the output stalls.
// Reset (rst_n low, synchronous): pipeline and skid emptied, registers to their defaults.
`include "cube_map_light_accumulate_macros.svh"

module cube_map_light_accumulate #(
  parameter int FACE_SIZE = cmla_pkg::FACE_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // texel words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cmla_pkg::FACE_W-1:0]    in_face_index,
  input  logic [cmla_pkg::TEXEL_W-1:0]   in_texel_x,
  input  logic [cmla_pkg::TEXEL_W-1:0]   in_texel_y,
  input  logic [cmla_pkg::COL_W-1:0]     in_red_in,
  input  logic [cmla_pkg::COL_W-1:0]     in_green_in,
  input  logic [cmla_pkg::COL_W-1:0]     in_blue_in,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cmla_pkg::COL_W-1:0]     out_red_out,
  output logic [cmla_pkg::COL_W-1:0]     out_green_out,
  output logic [cmla_pkg::COL_W-1:0]     out_blue_out,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cmla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmla_pkg::DIR_W-1:0]     cfg_data
);

  localparam int CW   = cmla_pkg::COL_W;
  localparam int LW   = cmla_pkg::DIR_W;
  // direction component width: covers +-FACE_SIZE and the texel offsets
  localparam int DW   = $clog2(FACE_SIZE + 32) + 1;
  localparam int PW   = 2 * DW + 34;           // divisor / dividend width
  localparam int QW   = 31;                    // quotient bits
  localparam int NDIV = 30;
  localparam int NSQ  = 16;
  localparam int NPOW = cmla_pkg::EXP_MAX - 1;

  // stage map
  localparam int S_IN   = 0;
  localparam int S_DIR  = S_IN + 1;
  localparam int S_MUL  = S_DIR + 1;
  localparam int S_SUM  = S_MUL + 1;
  localparam int S_WIDE = S_SUM + 1;
  localparam int S_DIV0 = S_WIDE + 1;
  localparam int S_DIVL = S_DIV0 + NDIV;
  localparam int S_SQL  = S_DIVL + NSQ;
  localparam int S_POWL = S_SQL + NPOW;
  localparam int S_LIT  = S_POWL + 1;
  localparam int S_OUT  = S_LIT + 1;
  localparam int NST    = S_OUT + 1;

  localparam logic signed [DW-1:0] FS = DW'(FACE_SIZE);
  localparam logic [QW-1:0]        Q_ONE = QW'(1) << 30;

  // ---------------- configuration ----------------
  logic signed [LW-1:0] dir_r [3];
  logic [CW-1:0]        light_r [3];
  logic [cmla_pkg::EXP_W-1:0] exp_r;
  logic signed [31:0]   lsq_r [3];
  logic [31:0]          ll_r;
  logic [cmla_pkg::EXP_W-1:0] exp_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r[0]   <= cmla_pkg::DIR_X_RST;
      dir_r[1]   <= cmla_pkg::DIR_Y_RST;
      dir_r[2]   <= cmla_pkg::DIR_Z_RST;
      light_r[0] <= cmla_pkg::COL_RST;
      light_r[1] <= cmla_pkg::COL_RST;
      light_r[2] <= cmla_pkg::COL_RST;
      exp_r      <= cmla_pkg::EXP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cmla_pkg::cfg_reg_t'(cfg_index))
        cmla_pkg::CFG_DIR_X:    dir_r[0]   <= $signed(cfg_data);
        cmla_pkg::CFG_DIR_Y:    dir_r[1]   <= $signed(cfg_data);
        cmla_pkg::CFG_DIR_Z:    dir_r[2]   <= $signed(cfg_data);
        cmla_pkg::CFG_RED:      light_r[0] <= cfg_data;
        cmla_pkg::CFG_GREEN:    light_r[1] <= cfg_data;
        cmla_pkg::CFG_BLUE:     light_r[2] <= cfg_data;
        cmla_pkg::CFG_EXPONENT: exp_r      <= cfg_data[cmla_pkg::EXP_W-1:0];
        default: ;
      endcase
    end
  end

  // |L|^2 is registered in lsq_r, then ll_r; the user writes only when idle, the block does not enforce it
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) lsq_r[i] <= dir_r[i] * dir_r[i];
    ll_r <= 32'(lsq_r[0]) + 32'(lsq_r[1]) + 32'(lsq_r[2]);
  end

  // exponent 0 acts as 1, above 32 as 32
  always_comb begin
    exp_eff = exp_r;
    if (exp_r == '0) exp_eff = cmla_pkg::EXP_W'(1);
    else if (exp_r > cmla_pkg::EXP_W'(cmla_pkg::EXP_MAX))
      exp_eff = cmla_pkg::EXP_W'(cmla_pkg::EXP_MAX);
  end

  // ---------------- input skid and flow control ----------------
  logic                          adv;
  logic                          skid_v_r;
  logic [cmla_pkg::FACE_W-1:0]   skid_face_r;
  logic [cmla_pkg::TEXEL_W-1:0]  skid_x_r, skid_y_r;
  logic [CW-1:0]                 skid_col_r [3];
  logic                          src_v;
  logic [NST-1:0]                v_r;

  assign adv      = !v_r[S_OUT] || out_ready;
  assign in_ready = !skid_v_r;
  assign src_v    = skid_v_r || in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (adv) begin
      skid_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_valid && in_ready) begin
      skid_face_r   <= in_face_index;
      skid_x_r      <= in_texel_x;
      skid_y_r      <= in_texel_y;
      skid_col_r[0] <= in_red_in;
      skid_col_r[1] <= in_green_in;
      skid_col_r[2] <= in_blue_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], src_v};
    end
  end

  // ---------------- datapath registers ----------------
  logic [cmla_pkg::FACE_W-1:0]  face_r;
  logic [cmla_pkg::TEXEL_W-1:0] tx_r, ty_r;
  logic [CW-1:0]                col_r [S_LIT+1][3];
  logic signed [DW-1:0]         d_r [3];
  logic signed [DW+LW-1:0]      pr_r [3];
  logic signed [2*DW-1:0]       sq_r [3];
  logic signed [DW+LW+1:0]      dot_r;
  logic [2*DW+1:0]              dd_r;
  logic [PW-1:0]                num_r, p_r;
  logic [QW-1:0]                dq_r [NDIV+1];
  logic [PW-1:0]                drem_r [NDIV+1];
  logic [PW-1:0]                dp_r [NDIV+1];
  logic [31:0]                  sv_r [1:NSQ];
  logic [31:0]                  sres_r [1:NSQ];
  logic [CW-1:0]                pf_r [1:NPOW];
  logic [CW-1:0]                pc_r [1:NPOW];
  logic [31:0]                  lp_r [3];
  logic [CW-1:0]                out_r [3];

  // combinational next values
  logic signed [DW-1:0]         ca, cb;
  logic signed [DW-1:0]         d_nxt [3];
  logic [DW+LW:0]               dmag;
  logic [PW-1:0]                num_nxt, p_nxt;
  logic                         zero_dir;
  logic [QW-1:0]                dq_nxt [NDIV+1];
  logic [PW-1:0]                drem_nxt [NDIV+1];
  logic [PW:0]                  rsh;
  logic [31:0]                  sv_in, sres_in, strial, sbit;
  logic [31:0]                  sv_nxt [1:NSQ];
  logic [31:0]                  sres_nxt [1:NSQ];
  logic [CW-1:0]                pf_in, pc_in;
  logic [31:0]                  pprod;
  logic [CW-1:0]                pf_nxt [1:NPOW];
  logic [CW-1:0]                cval;
  logic [CW+1:0]                osum;
  logic [CW-1:0]                out_nxt [3];

  // texel direction, scaled by FACE_SIZE
  always_comb begin
    ca = $signed(DW'({tx_r, 1'b1})) - FS;
    cb = $signed(DW'({ty_r, 1'b1})) - FS;
    case (cmla_pkg::face_t'(face_r))
      cmla_pkg::FACE_PX: begin d_nxt[0] = FS;  d_nxt[1] = -cb; d_nxt[2] = -ca; end
      cmla_pkg::FACE_NX: begin d_nxt[0] = -FS; d_nxt[1] = -cb; d_nxt[2] = ca;  end
      cmla_pkg::FACE_PY: begin d_nxt[0] = ca;  d_nxt[1] = FS;  d_nxt[2] = cb;  end
      cmla_pkg::FACE_NY: begin d_nxt[0] = ca;  d_nxt[1] = -FS; d_nxt[2] = -cb; end
      cmla_pkg::FACE_PZ: begin d_nxt[0] = ca;  d_nxt[1] = -cb; d_nxt[2] = FS;  end
      default:           begin d_nxt[0] = -ca; d_nxt[1] = -cb; d_nxt[2] = -FS; end
    endcase
  end

  // dot^2 and |d|^2 |L|^2; light behind or a zero light direction forces a zero quotient
  always_comb begin
    zero_dir = dot_r[DW+LW+1] || (dot_r == '0) || (ll_r == '0);
    dmag     = dot_r[DW+LW:0];
    num_nxt  = PW'(dmag * dmag);
    p_nxt    = PW'(dd_r * ll_r);
    if (zero_dir) begin
      num_nxt = '0;
      p_nxt   = PW'(1);
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    rsh = '0;
    dq_nxt[0]   = (num_r >= p_r) ? QW'(1) : '0;
    drem_nxt[0] = (num_r >= p_r) ? num_r - p_r : num_r;
    for (int k = 1; k <= NDIV; k++) begin
      rsh = {drem_r[k-1], 1'b0};
      if (rsh >= {1'b0, dp_r[k-1]}) begin
        drem_nxt[k] = PW'(rsh - {1'b0, dp_r[k-1]});
        dq_nxt[k]   = {dq_r[k-1][QW-2:0], 1'b1};
      end else begin
        drem_nxt[k] = rsh[PW-1:0];
        dq_nxt[k]   = {dq_r[k-1][QW-2:0], 1'b0};
      end
    end
  end

  // integer square root, one result bit per stage
  always_comb begin
    sv_in   = (dq_r[NDIV] > Q_ONE) ? 32'(Q_ONE) : 32'(dq_r[NDIV]);
    sres_in = '0;
    strial  = '0;
    sbit    = '0;
    for (int j = 1; j <= NSQ; j++) begin
      sbit   = 32'(1) << (32 - 2 * j);
      strial = sres_in + sbit;
      if (sv_in >= strial) begin
        sv_nxt[j]   = sv_in - strial;
        sres_nxt[j] = (sres_in >> 1) + sbit;
      end else begin
        sv_nxt[j]   = sv_in;
        sres_nxt[j] = sres_in >> 1;
      end
      if (j < NSQ) begin
        sv_in   = sv_r[j];
        sres_in = sres_r[j];
      end
    end
  end

  assign cval = sres_r[NSQ][CW-1:0];

  // power chain: stage k multiplies once more while k < exponent
  always_comb begin
    pf_in = cval;
    pc_in = cval;
    pprod = '0;
    for (int k = 1; k <= NPOW; k++) begin
      pprod = pf_in * pc_in;
      pf_nxt[k] = (cmla_pkg::EXP_W'(k) < exp_eff) ? pprod[30:15] : pf_in;
      if (k < NPOW) begin
        pf_in = pf_r[k];
        pc_in = pc_r[k];
      end
    end
  end

  // add and saturate
  always_comb begin
    osum = '0;
    for (int c = 0; c < 3; c++) begin
      osum = (CW+2)'(col_r[S_LIT][c]) + (CW+2)'(lp_r[c][31:15]);
      out_nxt[c] = (osum > (CW+2)'({CW{1'b1}})) ? {CW{1'b1}} : osum[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      face_r        <= skid_v_r ? skid_face_r : in_face_index;
      tx_r          <= skid_v_r ? skid_x_r : in_texel_x;
      ty_r          <= skid_v_r ? skid_y_r : in_texel_y;
      col_r[S_IN][0] <= skid_v_r ? skid_col_r[0] : in_red_in;
      col_r[S_IN][1] <= skid_v_r ? skid_col_r[1] : in_green_in;
      col_r[S_IN][2] <= skid_v_r ? skid_col_r[2] : in_blue_in;
      for (int s = 1; s <= S_LIT; s++) col_r[s] <= col_r[s-1];

      for (int i = 0; i < 3; i++) begin
        d_r[i]  <= d_nxt[i];
        pr_r[i] <= d_r[i] * dir_r[i];
        sq_r[i] <= d_r[i] * d_r[i];
      end
      dot_r <= (DW+LW+2)'(pr_r[0]) + (DW+LW+2)'(pr_r[1]) + (DW+LW+2)'(pr_r[2]);
      dd_r  <= (2*DW+2)'(sq_r[0]) + (2*DW+2)'(sq_r[1]) + (2*DW+2)'(sq_r[2]);
      num_r <= num_nxt;
      p_r   <= p_nxt;

      dp_r[0] <= p_r;
      for (int k = 0; k <= NDIV; k++) begin
        dq_r[k]   <= dq_nxt[k];
        drem_r[k] <= drem_nxt[k];
      end
      for (int k = 1; k <= NDIV; k++) dp_r[k] <= dp_r[k-1];

      for (int j = 1; j <= NSQ; j++) begin
        sv_r[j]   <= sv_nxt[j];
        sres_r[j] <= sres_nxt[j];
      end

      pc_r[1] <= cval;
      for (int k = 2; k <= NPOW; k++) pc_r[k] <= pc_r[k-1];
      for (int k = 1; k <= NPOW; k++) pf_r[k] <= pf_nxt[k];

      for (int c = 0; c < 3; c++) begin
        lp_r[c]  <= light_r[c] * pf_r[NPOW];
        out_r[c] <= out_nxt[c];
      end
    end
  end

  assign out_valid     = v_r[S_OUT];
  assign out_red_out   = out_r[0];
  assign out_green_out = out_r[1];
  assign out_blue_out  = out_r[2];

  // ---------------- checks ----------------
  // a stalled output freezes every stage
  `CMLA_ASSERT_NEXT(a_stall_freeze, out_valid && !out_ready, $stable(v_r), "pipeline moved while stalled")
  // the skid only fills on a stall
  `CMLA_ASSERT_NOW(a_skid_on_stall, $rose(skid_v_r), !$past(adv), "skid filled without stall")
  // clamped cosine never exceeds one
  `CMLA_ASSERT_NOW(a_cos_range, v_r[S_SQL], sres_r[NSQ] <= 32'(Q_ONE >> 15), "cosine above one")

endmodule

### bench/cmla_checker.sv
module cmla_checker
  import cmla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [FACE_W-1:0]    in_face_index,
  input  logic [TEXEL_W-1:0]   in_texel_x,
  input  logic [TEXEL_W-1:0]   in_texel_y,
  input  logic [COL_W-1:0]     in_red_in,
  input  logic [COL_W-1:0]     in_green_in,
  input  logic [COL_W-1:0]     in_blue_in,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [COL_W-1:0]     out_red_out,
  input  logic [COL_W-1:0]     out_green_out,
  input  logic [COL_W-1:0]     out_blue_out,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIR_W-1:0]     cfg_data,
  output int                   fails,
  output int                   owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FS = FACE_SIZE_DEF;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } texel_rgb_t;

  texel_rgb_t owed_colors[$];

  // shadow copy of the light registers
  longint               lx, ly, lz;
  logic [COL_W-1:0]     lrgb[3];
  logic [EXP_W-1:0]     lexp;

  initial begin
    fails = 0;
    owed  = 0;
  end

  task automatic report(input string msg);
    $display("cmla_checker: %s at %0t", msg, $time);
    fails++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt  = 64'd1 << 32;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // clamped cosine, unsigned Q1.15
  function automatic longint unsigned clamped_cos(input longint dx, input longint dy,
                                                  input longint dz);
    longint          dot;
    longint unsigned dd, ll, p, num, q, r;
    dot = dx * lx + dy * ly + dz * lz;
    dd  = dx * dx + dy * dy + dz * dz;
    ll  = lx * lx + ly * ly + lz * lz;
    if (dot <= 0 || dd == 0 || ll == 0) return 0;
    p   = dd * ll;
    num = dot * dot;
    q   = (num >= p) ? 1 : 0;
    r   = q ? num - p : num;
    for (int i = 0; i < 30; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= p) begin
        r -= p;
        q |= 1;
      end
    end
    if (q > (64'd1 << 30)) q = 64'd1 << 30;
    return int_sqrt(q);
  endfunction

  function automatic texel_rgb_t lit_texel(input logic [FACE_W-1:0] face,
                                           input logic [TEXEL_W-1:0] tx,
                                           input logic [TEXEL_W-1:0] ty,
                                           input texel_rgb_t base);
    longint          a, b, dx, dy, dz;
    longint unsigned c, fac, sum;
    int              e;
    logic [COL_W-1:0] chan[3];
    texel_rgb_t      res;
    a = 2 * longint'(tx) + 1 - FS;
    b = 2 * longint'(ty) + 1 - FS;
    case (face_t'(face))
      FACE_PX: begin dx = FS;  dy = -b; dz = -a; end
      FACE_NX: begin dx = -FS; dy = -b; dz = a;  end
      FACE_PY: begin dx = a;   dy = FS; dz = b;  end
      FACE_NY: begin dx = a;   dy = -FS; dz = -b; end
      FACE_PZ: begin dx = a;   dy = -b; dz = FS; end
      default: begin dx = -a;  dy = -b; dz = -FS; end  // -Z, and the two unused codes
    endcase
    c = clamped_cos(dx, dy, dz);
    e = lexp;
    if (e < 1) e = 1;
    if (e > EXP_MAX) e = EXP_MAX;
    fac = c;
    for (int k = 1; k < e; k++) fac = (fac * c) >> 15;
    chan[0] = base.red;
    chan[1] = base.green;
    chan[2] = base.blue;
    for (int ch = 0; ch < 3; ch++) begin
      sum = longint'(chan[ch]) + ((longint'(lrgb[ch]) * fac) >> 15);
      chan[ch] = (sum > 64'hFFFF) ? 16'hFFFF : sum[COL_W-1:0];
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    return res;
  endfunction

  always @(posedge clk) begin
    texel_rgb_t want;
    if (!rst_n) begin
      lx = DIR_X_RST;
      ly = DIR_Y_RST;
      lz = DIR_Z_RST;
      lrgb[0] = COL_RST;
      lrgb[1] = COL_RST;
      lrgb[2] = COL_RST;
      lexp = EXP_RST;
      owed_colors.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_DIR_X:    lx = longint'($signed(cfg_data));
          CFG_DIR_Y:    ly = longint'($signed(cfg_data));
          CFG_DIR_Z:    lz = longint'($signed(cfg_data));
          CFG_RED:      lrgb[0] = cfg_data;
          CFG_GREEN:    lrgb[1] = cfg_data;
          CFG_BLUE:     lrgb[2] = cfg_data;
          CFG_EXPONENT: lexp = cfg_data[EXP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_colors.size() == 0) begin
          report("unexpected result word");
        end else begin
          want = owed_colors.pop_front();
          if (out_red_out !== want.red)
            report($sformatf("red mismatch: got %h, want %h", out_red_out, want.red));
          if (out_green_out !== want.green)
            report($sformatf("green mismatch: got %h, want %h", out_green_out, want.green));
          if (out_blue_out !== want.blue)
            report($sformatf("blue mismatch: got %h, want %h", out_blue_out, want.blue));
        end
      end
      if (in_valid && in_ready)
        owed_colors.push_back(lit_texel(in_face_index, in_texel_x, in_texel_y,
                                        {in_red_in, in_green_in, in_blue_in}));
    end
    owed = owed_colors.size();
  end

endmodule

### bench/tb_top.sv
module tb_top;
  import cmla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT  = 84;
  localparam int LONG_HOLD = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FACE_W-1:0]    in_face_index = '0;
  logic [TEXEL_W-1:0]   in_texel_x = '0;
  logic [TEXEL_W-1:0]   in_texel_y = '0;
  logic [COL_W-1:0]     in_red_in = '0;
  logic [COL_W-1:0]     in_green_in = '0;
  logic [COL_W-1:0]     in_blue_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COL_W-1:0]     out_red_out;
  logic [COL_W-1:0]     out_green_out;
  logic [COL_W-1:0]     out_blue_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIR_W-1:0]     cfg_data = '0;

  int fails;
  int owed;

  // pacing controls for the sender and the receiver
  bit calm = 1'b0;       // last part of the run: no idling anywhere
  bit hold_req = 1'b0;   // ask the receiver for one long stall
  bit send_gaps = 1'b1;  // sender may idle between words

  cube_map_light_accumulate dut (.*);

  cmla_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // Receiver: random stall bursts, one long stall on request, none at the end.
  initial begin
    forever begin
      @(negedge clk);
      if (calm || !rst_n) begin
        out_ready = 1'b1;
      end else if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req  = 1'b0;
        out_ready = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(0, 20)) begin
          @(negedge clk);
          if (hold_req) break;
        end
      end
    end
  end

  // One texel word: payload goes up at the falling edge, held until taken.
  task automatic push_texel(input logic [FACE_W-1:0] face, input logic [TEXEL_W-1:0] tx,
                            input logic [TEXEL_W-1:0] ty, input logic [COL_W-1:0] r,
                            input logic [COL_W-1:0] g, input logic [COL_W-1:0] b);
    if (send_gaps && !calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_face_index = face;
    in_texel_x    = tx;
    in_texel_y    = ty;
    in_red_in     = r;
    in_green_in   = g;
    in_blue_in    = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid = 1'b0;
  endtask

  // Register write; only called once the block has drained.
  task automatic write_reg(input cfg_reg_t idx, input logic [DIR_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (owed != 0) @(negedge clk);
    repeat (PIPE_LAT + 6) @(negedge clk);
  endtask

  task automatic load_light(input logic [DIR_W-1:0] x, input logic [DIR_W-1:0] y,
                            input logic [DIR_W-1:0] z, input logic [COL_W-1:0] r,
                            input logic [COL_W-1:0] g, input logic [COL_W-1:0] b,
                            input logic [DIR_W-1:0] e);
    drain();
    write_reg(CFG_DIR_X, x);
    write_reg(CFG_DIR_Y, y);
    write_reg(CFG_DIR_Z, z);
    write_reg(CFG_RED, r);
    write_reg(CFG_GREEN, g);
    write_reg(CFG_BLUE, b);
    write_reg(CFG_EXPONENT, e);
  endtask

  // colour that leans on the extremes now and then
  function automatic logic [COL_W-1:0] any_color();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'(($urandom_range(0, 15)) << 12) | 16'hF000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_texels(input int n);
    repeat (n)
      push_texel(3'($urandom_range(0, 7)), 4'($urandom), 4'($urandom),
                 any_color(), any_color(), any_color());
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed words under the reset light (+X, white, exponent one).
    // Every face plus the two unused codes, corner and centre texels.
    for (int f = 0; f < 8; f++)
      push_texel(3'(f), 4'd0, 4'd15, 16'h0000, 16'h1234, 16'hFFFF);
    push_texel(FACE_PX, 4'd7, 4'd8, 16'h0000, 16'h0000, 16'h0000);
    push_texel(FACE_PX, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_texel(FACE_PX, 4'd0, 4'd0, 16'hF000, 16'hEFFF, 16'h8000);
    push_texel(FACE_NX, 4'd8, 4'd7, 16'h0001, 16'h0002, 16'h0003);

    // Zero light direction: colour must pass untouched.
    load_light(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    for (int f = 0; f < 6; f++)
      push_texel(3'(f), 4'd7, 4'd7, 16'h0abc, 16'hFFFF, 16'h0000);

    // Most negative direction, strongest light, exponent zero reads as one.
    load_light(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    random_texels(60);

    // Sharp lobe at the maximum exponent; long receiver stall fills the pipe.
    load_light(16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'hFFFF, 16'd32);
    send_gaps = 1'b0;
    hold_req  = 1'b1;
    random_texels(70);
    send_gaps = 1'b1;

    // Exponent above the limit saturates; oversize data bits are dropped.
    load_light(16'h1234, 16'hC000, 16'h7FFF, 16'h0000, 16'h1000, 16'h4000, 16'hFFFF);
    random_texels(60);

    load_light(16'(-1), 16'h0001, 16'h0000, 16'h3000, 16'h2000, 16'h1000, 16'd33);
    random_texels(60);

    load_light(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 16'd16);
    random_texels(60);

    // Last part: random light, no idling on either side.
    load_light(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom_range(1, 32)));
    calm = 1'b1;
    random_texels(60);
    stop_sending();

    while (owed != 0) @(posedge clk);
    repeat (PIPE_LAT + 16) @(posedge clk);
    if (fails == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/cmla_pkg.sv
src/cube_map_light_accumulate.sv
bench/cmla_checker.sv
bench/tb_top.sv
